### rtl/guillotine_first_fit_plank_allocator_unit_assert.svh
// Assertion macros shared by the allocator RTL.
// Each macro checks one implication on the rising clock edge while reset is released.
`ifndef GUILLOTINE_FIRST_FIT_PLANK_ALLOCATOR_UNIT_ASSERT_SVH
`define GUILLOTINE_FIRST_FIT_PLANK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define GFFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define GFFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define GFFP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GFFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/gffp_pkg.sv
package gffp_pkg;

    // Table geometry and length format.
    localparam int TABLE_SLOTS = 16;
    localparam int LENGTH_BITS = 16;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int AREA_W      = 2 * LENGTH_BITS;

    // Configuration register file.
    localparam int CFG_W          = 16;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam logic [CFG_W-1:0] MIN_KEEP_RESET = 16'd5;
    localparam logic [PADDR_W-3:0] REG_MIN_KEEP = '0;

    // Stream beat widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    // Request kinds.
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_CUT = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_TOO_SMALL = 3'd1,
        ST_FULL      = 3'd2,
        ST_PLACED    = 3'd3,
        ST_NO_FIT    = 3'd4,
        ST_LOST      = 3'd5
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DROP,
        S_MUL_R,
        S_MUL_B,
        S_PUSH1,
        S_PUSH2,
        S_DONE
    } t_state;

    // True when a length reaches the keep threshold.
    function automatic logic len_kept(input logic [LENGTH_BITS-1:0] len,
                                      input logic [CFG_W-1:0] mk);
        return 32'(len) >= 32'(mk);
    endfunction

endpackage

### rtl/guillotine_first_fit_plank_allocator_unit.sv
// Guillotine first-fit plank allocator. The block holds up to TABLE_SLOTS free stock
// pieces, newest first. An input beat with tuser 0 adds a piece (dropped when a side is
// below min_keep, ignored when the table is full); tuser 1 requests a rectangle, which is
// cut from the first piece that holds it as given or turned 90 degrees, and the kept right
// and bottom offcuts go back to the front of the table, the smaller one by area in front.
// Every input beat yields exactly one output beat. One item is worked at a time and
// s_axis_tready is high only while the sequencer is idle. An add passes through the
// add and done states to the output register. A cut scans one table entry per cycle
// through a single fit comparator, then removes the piece, forms both offcut areas in
// turn on one shared 16x16 multiplier and inserts up to two offcuts, one per cycle. A
// full output register holds the sequencer in its final state until the beat is taken.
// min_keep is at byte address 0 of the register port and resets to 5.
`include "guillotine_first_fit_plank_allocator_unit_assert.svh"
module guillotine_first_fit_plank_allocator_unit
    import gffp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] item_width, [31:16] item_height
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [0] req_type
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] used_width, [31:16] used_height, [36:32] free_count, [39:37] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser,  // [2:0] status, [3] rotated
    // Register port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // Control state.
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CFG_W-1:0]       r_min_keep;
    logic                   r_m_valid;

    // Free piece table.
    logic [LENGTH_BITS-1:0] r_tbl_w [TABLE_SLOTS];
    logic [LENGTH_BITS-1:0] r_tbl_h [TABLE_SLOTS];

    // Working item.
    logic                   r_req;
    logic [LENGTH_BITS-1:0] r_iw, r_ih;
    logic [LENGTH_BITS-1:0] r_pw, r_ph, r_rw, r_rh;
    logic [LENGTH_BITS-1:0] r_rgt_w, r_bot_h;
    logic [AREA_W-1:0]      r_area_r;
    logic                   r_rot, r_keep_r, r_keep_b, r_right_first, r_lost;
    t_status                r_status, n_status;

    // Output beat registers.
    logic [M_TDATA_W-1:0]   r_m_data;
    logic [M_TUSER_W-1:0]   r_m_user;

    // Datapath controls.
    logic                   w_accept, w_fit_n, w_fit_r, w_scan_end, w_out_free;
    logic                   w_push_req, w_push_do, w_drop, w_load_out, w_table_full;
    logic [LENGTH_BITS-1:0] w_ent_w, w_ent_h, w_push_w, w_push_h;
    logic [LENGTH_BITS-1:0] w_mul_a, w_mul_b;
    logic [AREA_W-1:0]      w_prod;
    logic                   w_cfg_wr;

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_out_free   = !r_m_valid || m_axis_tready;
    assign w_table_full = (r_count == CNT_W'(TABLE_SLOTS));
    assign w_scan_end   = (r_idx >= r_count);

    // Scan read port and the shared fit comparator.
    assign w_ent_w = r_tbl_w[r_idx[IDX_W-1:0]];
    assign w_ent_h = r_tbl_h[r_idx[IDX_W-1:0]];
    assign w_fit_n = (r_iw <= w_ent_w) && (r_ih <= w_ent_h);
    assign w_fit_r = (r_ih <= w_ent_w) && (r_iw <= w_ent_h);

    // Shared multiplier: right offcut area first, then bottom offcut area.
    always_comb begin
        if (r_state == S_MUL_B) begin
            w_mul_a = r_rw;
            w_mul_b = r_bot_h;
        end else begin
            w_mul_a = r_rgt_w;
            w_mul_b = r_ph;
        end
    end
    assign w_prod = AREA_W'(w_mul_a) * AREA_W'(w_mul_b);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser[0] == REQ_ADD) ? S_ADD : S_SCAN;
                end
            end
            S_ADD:   n_state = S_DONE;
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_DONE;
                end else if (w_fit_n || w_fit_r) begin
                    n_state = S_DROP;
                end
            end
            S_DROP:  n_state = S_MUL_R;
            S_MUL_R: n_state = S_MUL_B;
            S_MUL_B: n_state = S_PUSH1;
            S_PUSH1: n_state = (r_keep_r && r_keep_b) ? S_PUSH2 : S_DONE;
            S_PUSH2: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic of the sequencer: table moves, counters and status.
    always_comb begin
        s_axis_tready = 1'b0;
        n_idx         = r_idx;
        n_status      = r_status;
        w_push_req    = 1'b0;
        w_push_w      = r_rgt_w;
        w_push_h      = r_ph;
        w_drop        = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                n_idx         = '0;
                n_status      = ST_PLACED;
            end
            S_ADD: begin
                w_push_w = r_iw;
                w_push_h = r_ih;
                if (!len_kept(r_iw, r_min_keep) || !len_kept(r_ih, r_min_keep)) begin
                    n_status = ST_TOO_SMALL;
                end else if (w_table_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status   = ST_ADDED;
                    w_push_req = 1'b1;
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_status = ST_NO_FIT;
                end else if (!(w_fit_n || w_fit_r)) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DROP: begin
                w_drop = 1'b1;
            end
            S_PUSH1: begin
                if (r_keep_r && r_keep_b) begin
                    w_push_req = 1'b1;
                    if (!r_right_first) begin
                        w_push_w = r_rw;
                        w_push_h = r_bot_h;
                    end
                end else if (r_keep_r) begin
                    w_push_req = 1'b1;
                end else if (r_keep_b) begin
                    w_push_req = 1'b1;
                    w_push_w   = r_rw;
                    w_push_h   = r_bot_h;
                end
            end
            S_PUSH2: begin
                w_push_req = 1'b1;
                if (r_right_first) begin
                    w_push_w = r_rw;
                    w_push_h = r_bot_h;
                end
            end
            S_DONE: begin
                w_load_out = w_out_free;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    assign w_push_do = w_push_req && !w_table_full;

    // Piece count follows removals and insertions.
    always_comb begin
        n_count = r_count;
        if (w_drop) begin
            n_count = r_count - 1'b1;
        end else if (w_push_do) begin
            n_count = r_count + 1'b1;
        end
    end

    // Register write decode on the access phase.
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[PADDR_W-1:2] == REG_MIN_KEEP) ? PDATA_W'(r_min_keep) : '0;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_min_keep <= MIN_KEEP_RESET;
            r_m_valid  <= 1'b0;
            r_status   <= ST_ADDED;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_status <= n_status;
            if (w_cfg_wr && (paddr[PADDR_W-1:2] == REG_MIN_KEEP)) begin
                r_min_keep <= pwdata[CFG_W-1:0];
            end
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Table shifts: removal closes the gap, insertion opens slot zero.
    always_ff @(posedge i_clk) begin
        if (w_drop) begin
            for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
                if (CNT_W'(i) >= r_idx) begin
                    r_tbl_w[i] <= r_tbl_w[i+1];
                    r_tbl_h[i] <= r_tbl_h[i+1];
                end
            end
        end else if (w_push_do) begin
            for (int i = 1; i < TABLE_SLOTS; i++) begin
                r_tbl_w[i] <= r_tbl_w[i-1];
                r_tbl_h[i] <= r_tbl_h[i-1];
            end
            r_tbl_w[0] <= w_push_w;
            r_tbl_h[0] <= w_push_h;
        end
    end

    // Working item payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= s_axis_tuser[0];
            r_iw   <= s_axis_tdata[LENGTH_BITS-1:0];
            r_ih   <= s_axis_tdata[2*LENGTH_BITS-1:LENGTH_BITS];
            r_rot  <= 1'b0;
            r_lost <= 1'b0;
        end
        // The first fitting piece is captured with its orientation.
        if (r_state == S_SCAN && !w_scan_end && (w_fit_n || w_fit_r)) begin
            r_pw  <= w_ent_w;
            r_ph  <= w_ent_h;
            r_rot <= !w_fit_n;
            r_rw  <= w_fit_n ? r_iw : r_ih;
            r_rh  <= w_fit_n ? r_ih : r_iw;
        end
        // Offcut sides after the vertical and horizontal cuts.
        if (w_drop) begin
            r_rgt_w <= r_pw - r_rw;
            r_bot_h <= r_ph - r_rh;
        end
        if (r_state == S_MUL_R) begin
            r_area_r <= w_prod;
            r_keep_r <= len_kept(r_rgt_w, r_min_keep);
            r_keep_b <= len_kept(r_bot_h, r_min_keep);
        end
        // A larger right offcut goes in first so the smaller bottom one ends in front.
        if (r_state == S_MUL_B) begin
            r_right_first <= (r_area_r > w_prod);
        end
        if (w_push_req && w_table_full && r_req == REQ_CUT) begin
            r_lost <= 1'b1;
        end
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (r_req == REQ_CUT && r_status != ST_NO_FIT) begin
                r_m_user <= {r_rot, (r_lost ? ST_LOST : ST_PLACED)};
                r_m_data <= {3'b000, r_count, 16'(r_ph), 16'(r_pw)};
            end else begin
                r_m_user <= {1'b0, r_status};
                r_m_data <= {3'b000, r_count, 32'd0};
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // The table never holds more pieces than it has slots.
    `GFFP_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(TABLE_SLOTS))
    // A scan hit always lies inside the occupied part of the table.
    `GFFP_ASSERT_SAME(a_hit_in_table, i_clk, i_rst_n,
        r_state == S_SCAN && (w_fit_n || w_fit_r) && !w_scan_end, r_idx < r_count)
    // The table is untouched while no item is in work.
    `GFFP_ASSERT_NEXT(a_idle_count, i_clk, i_rst_n, r_state == S_IDLE, $stable(r_count))
    // An accepted add leaves at least one piece in the table.
    `GFFP_ASSERT_SAME(a_added_nonempty, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[2:0] == ST_ADDED, m_axis_tdata[36:32] != 5'd0)

endmodule
